### hdl/pba_pkg.sv
// Shared types, codes and sizes for the paragraph block allocator
`default_nettype none

package pba_pkg;

    localparam int ARENA_PARAS = 4096;
    localparam int ADDR_W      = $clog2(ARENA_PARAS);
    localparam int SIZE_W      = 16;
    localparam int PTR_W       = SIZE_W + 2;
    localparam int REQ_W       = 12;
    localparam int PARA_W      = 16;
    localparam int OWNER_W     = 16;
    localparam int MERGE_LIMIT = 2 * ARENA_PARAS;
    localparam int STEP_W      = $clog2(MERGE_LIMIT + 2);

    localparam logic [2:0] OP_ALLOC   = 3'd0;
    localparam logic [2:0] OP_FREE    = 3'd1;
    localparam logic [2:0] OP_RESIZE  = 3'd2;
    localparam logic [2:0] OP_LARGEST = 3'd3;
    localparam logic [2:0] OP_CHECK   = 3'd4;
    localparam logic [2:0] OP_FOWNER  = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_CORRUPT = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic [1:0] FIT_FIRST   = 2'd0;
    localparam logic [1:0] FIT_BEST    = 2'd1;
    localparam logic [1:0] FIT_LAST    = 2'd2;
    localparam logic [1:0] FIT_LARGEST = 2'd3;

    localparam logic CFG_STRATEGY = 1'b0;
    localparam logic CFG_BASE     = 1'b1;

    typedef struct packed {
        logic                valid;
        logic                last;
        logic [OWNER_W-1:0]  owner;
        logic [SIZE_W-1:0]   size;
    } hdr_t;

    localparam int HDR_W = $bits(hdr_t);

    localparam hdr_t RESET_HDR = '{valid: 1'b1, last: 1'b1, owner: '0,
                                   size: SIZE_W'(ARENA_PARAS - 1)};

    typedef struct packed {
        logic [2:0]          op;
        logic [REQ_W-1:0]    req_size;
        logic [PARA_W-1:0]   block_para;
        logic [OWNER_W-1:0]  owner;
    } pba_req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [PARA_W-1:0]   para_out;
        logic [REQ_W-1:0]    size_out;
    } pba_rsp_t;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   addr;
        logic [HDR_W-1:0]    data;
    } mem_wr_t;

endpackage

`default_nettype wire

### hdl/pba_ram.sv
// Generic single write, single read RAM with registered read data
`default_nettype none

module pba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/pba_ctrl.sv
// Header chain sequencer: walks, splits, merges and resizes blocks in the header RAM
`default_nettype none

module pba_ctrl
    import pba_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire pba_req_t           in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output pba_rsp_t                out_data,
    input  wire logic [1:0]         strategy,
    input  wire logic [PARA_W-1:0]  base,
    output mem_wr_t                 mem_wr,
    output logic [ADDR_W-1:0]       mem_raddr,
    input  wire logic [HDR_W-1:0]   mem_rdata
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_A_WALK, S_A_DECIDE, S_A_SPLIT_C, S_F_CHK,
        S_R_CHK, S_R_Q, S_R_SHP, S_R_WP, S_R_WN, S_M_START, S_M_LOAD,
        S_M_EVAL, S_M_Q, S_W_DATA, S_W_POST, S_FIN
    } state_t;

    localparam logic [PTR_W-1:0] LIM = PTR_W'(ARENA_PARAS);

    state_t              state_reg, state_next;
    logic [2:0]          op_reg, op_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [OWNER_W-1:0]  own_reg, own_next;
    logic [ADDR_W-1:0]   wp_reg, wp_next;
    logic [ADDR_W-1:0]   rp_reg, rp_next;
    logic [ADDR_W-1:0]   mp_reg, mp_next;
    logic [ADDR_W-1:0]   q_reg, q_next;
    logic [ADDR_W-1:0]   n_reg, n_next;
    logic [ADDR_W-1:0]   cand_reg, cand_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    hdr_t                hp_reg, hp_next;
    hdr_t                hq_reg, hq_next;
    logic                found_reg, found_next;
    logic                clast_reg, clast_next;
    logic [SIZE_W-1:0]   csz_reg, csz_next;
    logic [SIZE_W-1:0]   best_reg, best_next;
    logic [STEP_W-1:0]   steps_reg, steps_next;
    pba_rsp_t            res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    pba_rsp_t            out_data_reg, out_data_next;

    hdr_t                d;
    hdr_t                hnew;
    logic [SIZE_W-1:0]   req16, want, delta, best_upd, grow_max;
    logic [PTR_W-1:0]    wnxt, a_n, m_q, r_gq, r_sq, r_n;
    logic [PARA_W-1:0]   rel_free, rel_rsz, rp_abs;
    logic                fr, ge, take, md, walk_adv;
    logic [1:0]          md_st;

    assign d        = hdr_t'(mem_rdata);
    assign req16    = SIZE_W'(req_reg);
    assign want     = (strategy == FIT_LARGEST) ? csz_reg : req16;
    assign wnxt     = PTR_W'(wp_reg) + PTR_W'(d.size) + PTR_W'(1);
    assign a_n      = (strategy != FIT_LAST)
                      ? PTR_W'(cand_reg) + PTR_W'(want) + PTR_W'(1)
                      : PTR_W'(cand_reg) + PTR_W'(csz_reg - want);
    assign m_q      = PTR_W'(mp_reg) + PTR_W'(hp_reg.size) + PTR_W'(1);
    assign r_gq     = PTR_W'(rp_reg) + PTR_W'(d.size) + PTR_W'(1);
    assign r_sq     = PTR_W'(rp_reg) + PTR_W'(req16) + PTR_W'(1);
    assign delta    = req16 - hp_reg.size;
    assign r_n      = PTR_W'(q_reg) + PTR_W'(delta);
    assign grow_max = hp_reg.size + d.size;
    assign rel_free = in_data.block_para - base;
    assign rel_rsz  = in_data.block_para - PARA_W'(1) - base;
    assign rp_abs   = PARA_W'(rp_reg) + base;
    assign fr       = (d.owner == '0);
    assign ge       = (d.size >= req16);
    assign best_upd = (op_reg == OP_LARGEST && fr && d.size > best_reg) ? d.size : best_reg;

    always_comb
    begin
        unique case (strategy)
            FIT_FIRST:   take = fr && ge;
            FIT_BEST:    take = fr && ge && (!found_reg || d.size < csz_reg);
            FIT_LAST:    take = fr && ge;
            FIT_LARGEST: take = fr && (!found_reg || d.size > csz_reg);
            default:     take = 1'b0;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        req_next       = req_reg;
        own_next       = own_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        mp_next        = mp_reg;
        q_next         = q_reg;
        n_next         = n_reg;
        cand_next      = cand_reg;
        clr_next       = clr_reg;
        hp_next        = hp_reg;
        hq_next        = hq_reg;
        found_next     = found_reg;
        clast_next     = clast_reg;
        csz_next       = csz_reg;
        best_next      = best_reg;
        steps_next     = steps_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        mem_wr         = '0;
        mem_raddr      = '0;
        md             = 1'b0;
        md_st          = ST_OK;
        walk_adv       = 1'b0;
        hnew           = hp_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = clr_reg;
                mem_wr.data = (clr_reg == '0) ? RESET_HDR : '0;
                clr_next    = clr_reg + ADDR_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_data.op;
                    req_next   = in_data.req_size;
                    own_next   = in_data.owner;
                    found_next = 1'b0;
                    csz_next   = '0;
                    best_next  = '0;
                    wp_next    = '0;
                    res_next   = '{status: ST_INVALID, para_out: '0, size_out: '0};
                    unique case (in_data.op) inside
                        OP_ALLOC, OP_LARGEST, OP_CHECK, OP_FOWNER:
                        begin
                            mem_raddr  = '0;
                            state_next = (in_data.op == OP_ALLOC) ? S_A_WALK : S_W_DATA;
                        end
                        OP_FREE:
                        begin
                            if (PTR_W'(rel_free) < LIM)
                            begin
                                rp_next    = rel_free[ADDR_W-1:0];
                                mem_raddr  = rel_free[ADDR_W-1:0];
                                state_next = S_F_CHK;
                            end
                            else
                            begin
                                state_next = S_FIN;
                            end
                        end
                        OP_RESIZE:
                        begin
                            if (PTR_W'(rel_rsz) < LIM)
                            begin
                                rp_next    = rel_rsz[ADDR_W-1:0];
                                mem_raddr  = rel_rsz[ADDR_W-1:0];
                                state_next = S_R_CHK;
                            end
                            else
                            begin
                                state_next = S_FIN;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_A_WALK:
            begin
                if (!d.valid)
                begin
                    res_next   = '{status: ST_CORRUPT, para_out: '0, size_out: '0};
                    state_next = S_FIN;
                end
                else
                begin
                    if (take)
                    begin
                        cand_next  = wp_reg;
                        csz_next   = d.size;
                        clast_next = d.last;
                        found_next = 1'b1;
                    end
                    if ((take && strategy == FIT_FIRST) || d.last)
                    begin
                        state_next = S_A_DECIDE;
                    end
                    else if (wnxt >= LIM)
                    begin
                        res_next   = '{status: ST_CORRUPT, para_out: '0, size_out: '0};
                        state_next = S_FIN;
                    end
                    else
                    begin
                        wp_next   = wnxt[ADDR_W-1:0];
                        mem_raddr = wnxt[ADDR_W-1:0];
                    end
                end
            end

            S_A_DECIDE:
            begin
                if (!found_reg)
                begin
                    res_next   = '{status: ST_NOMEM, para_out: '0, size_out: '0};
                    state_next = S_FIN;
                end
                else if (csz_reg > want)
                begin
                    if (a_n >= LIM)
                    begin
                        res_next   = '{status: ST_CORRUPT, para_out: '0, size_out: '0};
                        state_next = S_FIN;
                    end
                    else
                    begin
                        mem_wr.we   = 1'b1;
                        mem_wr.addr = a_n[ADDR_W-1:0];
                        mem_wr.data = (strategy != FIT_LAST)
                            ? hdr_t'{valid: 1'b1, last: clast_reg, owner: '0,
                                     size: csz_reg - want - SIZE_W'(1)}
                            : hdr_t'{valid: 1'b1, last: clast_reg, owner: own_reg,
                                     size: want};
                        state_next  = S_A_SPLIT_C;
                    end
                end
                else
                begin
                    mem_wr.we   = 1'b1;
                    mem_wr.addr = cand_reg;
                    mem_wr.data = hdr_t'{valid: 1'b1, last: clast_reg, owner: own_reg,
                                         size: csz_reg};
                    res_next    = '{status: ST_OK, para_out: PARA_W'(cand_reg) + base,
                                    size_out: want[REQ_W-1:0]};
                    state_next  = S_FIN;
                end
            end

            S_A_SPLIT_C:
            begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = cand_reg;
                if (strategy != FIT_LAST)
                begin
                    mem_wr.data = hdr_t'{valid: 1'b1, last: 1'b0, owner: own_reg, size: want};
                    res_next    = '{status: ST_OK, para_out: PARA_W'(cand_reg) + base,
                                    size_out: want[REQ_W-1:0]};
                end
                else
                begin
                    mem_wr.data = hdr_t'{valid: 1'b1, last: 1'b0, owner: '0,
                                         size: csz_reg - want - SIZE_W'(1)};
                    res_next    = '{status: ST_OK,
                                    para_out: PARA_W'(a_n[ADDR_W-1:0]) + base,
                                    size_out: want[REQ_W-1:0]};
                end
                state_next = S_FIN;
            end

            S_F_CHK:
            begin
                if (!d.valid)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    mem_wr.we   = 1'b1;
                    mem_wr.addr = rp_reg;
                    mem_wr.data = hdr_t'{valid: d.valid, last: d.last, owner: '0,
                                         size: d.size};
                    state_next  = S_M_START;
                end
            end

            S_R_CHK:
            begin
                hp_next = d;
                if (!d.valid)
                begin
                    res_next   = '{status: ST_CORRUPT, para_out: '0, size_out: '0};
                    state_next = S_FIN;
                end
                else if (req16 > d.size)
                begin
                    if (d.last)
                    begin
                        res_next   = '{status: ST_NOMEM, para_out: '0,
                                       size_out: d.size[REQ_W-1:0]};
                        state_next = S_FIN;
                    end
                    else if (r_gq >= LIM)
                    begin
                        res_next   = '{status: ST_CORRUPT, para_out: '0, size_out: '0};
                        state_next = S_FIN;
                    end
                    else
                    begin
                        q_next     = r_gq[ADDR_W-1:0];
                        mem_raddr  = r_gq[ADDR_W-1:0];
                        state_next = S_R_Q;
                    end
                end
                else if (req16 < d.size)
                begin
                    if (r_sq >= LIM)
                    begin
                        res_next   = '{status: ST_CORRUPT, para_out: '0, size_out: '0};
                        state_next = S_FIN;
                    end
                    else
                    begin
                        mem_wr.we   = 1'b1;
                        mem_wr.addr = r_sq[ADDR_W-1:0];
                        mem_wr.data = hdr_t'{valid: 1'b1, last: d.last, owner: '0,
                                             size: d.size - req16 - SIZE_W'(1)};
                        state_next  = S_R_SHP;
                    end
                end
                else
                begin
                    res_next   = '{status: ST_OK, para_out: rp_abs, size_out: req_reg};
                    state_next = S_FIN;
                end
            end

            S_R_SHP:
            begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = rp_reg;
                mem_wr.data = hdr_t'{valid: hp_reg.valid, last: 1'b0, owner: hp_reg.owner,
                                     size: req16};
                state_next  = S_M_START;
            end

            S_R_Q:
            begin
                if (!d.valid)
                begin
                    res_next   = '{status: ST_CORRUPT, para_out: '0, size_out: '0};
                    state_next = S_FIN;
                end
                else if (!fr)
                begin
                    res_next   = '{status: ST_NOMEM, para_out: '0,
                                   size_out: hp_reg.size[REQ_W-1:0]};
                    state_next = S_FIN;
                end
                else if (d.size < delta)
                begin
                    res_next   = '{status: ST_NOMEM, para_out: '0,
                                   size_out: grow_max[REQ_W-1:0]};
                    state_next = S_FIN;
                end
                else if (r_n >= LIM)
                begin
                    res_next   = '{status: ST_CORRUPT, para_out: '0, size_out: '0};
                    state_next = S_FIN;
                end
                else
                begin
                    hq_next     = hdr_t'{valid: d.valid, last: d.last, owner: d.owner,
                                         size: d.size - delta};
                    mem_wr.we   = 1'b1;
                    mem_wr.addr = q_reg;
                    mem_wr.data = hq_next;
                    n_next      = r_n[ADDR_W-1:0];
                    state_next  = S_R_WP;
                end
            end

            S_R_WP:
            begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = rp_reg;
                mem_wr.data = hdr_t'{valid: hp_reg.valid, last: hp_reg.last,
                                     owner: hp_reg.owner, size: req16};
                state_next  = S_R_WN;
            end

            S_R_WN:
            begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = n_reg;
                mem_wr.data = hq_reg;
                res_next    = '{status: ST_OK, para_out: rp_abs, size_out: req_reg};
                state_next  = S_FIN;
            end

            S_M_START:
            begin
                mp_next    = '0;
                steps_next = '0;
                mem_raddr  = '0;
                state_next = S_M_LOAD;
            end

            S_M_LOAD:
            begin
                hp_next = d;
                if (!d.valid)
                begin
                    md    = 1'b1;
                    md_st = ST_CORRUPT;
                end
                else
                begin
                    state_next = S_M_EVAL;
                end
            end

            S_M_EVAL:
            begin
                if (hp_reg.last)
                begin
                    md = 1'b1;
                end
                else if (steps_reg >= STEP_W'(MERGE_LIMIT) || m_q >= LIM)
                begin
                    md    = 1'b1;
                    md_st = ST_CORRUPT;
                end
                else
                begin
                    steps_next = steps_reg + STEP_W'(1);
                    q_next     = m_q[ADDR_W-1:0];
                    mem_raddr  = m_q[ADDR_W-1:0];
                    state_next = S_M_Q;
                end
            end

            S_M_Q:
            begin
                if (!d.valid)
                begin
                    md    = 1'b1;
                    md_st = ST_CORRUPT;
                end
                else if (hp_reg.owner == '0 && fr)
                begin
                    hnew        = hdr_t'{valid: hp_reg.valid, last: d.last,
                                         owner: hp_reg.owner,
                                         size: hp_reg.size + d.size + SIZE_W'(1)};
                    hp_next     = hnew;
                    mem_wr.we   = 1'b1;
                    mem_wr.addr = mp_reg;
                    mem_wr.data = hnew;
                    state_next  = S_M_EVAL;
                end
                else
                begin
                    mp_next    = q_reg;
                    hp_next    = d;
                    state_next = S_M_EVAL;
                end
            end

            S_W_DATA:
            begin
                if (!d.valid)
                begin
                    res_next   = '{status: ST_CORRUPT, para_out: '0, size_out: '0};
                    state_next = S_FIN;
                end
                else
                begin
                    best_next = best_upd;
                    if (op_reg == OP_FOWNER && d.owner == own_reg)
                    begin
                        mem_wr.we   = 1'b1;
                        mem_wr.addr = wp_reg;
                        mem_wr.data = hdr_t'{valid: d.valid, last: d.last, owner: '0,
                                             size: d.size};
                        state_next  = S_M_START;
                    end
                    else
                    begin
                        walk_adv = 1'b1;
                    end
                end
            end

            S_W_POST:
            begin
                walk_adv = 1'b1;
            end

            S_FIN:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // end of a merge pass: back to the caller
        if (md)
        begin
            if (op_reg == OP_FOWNER)
            begin
                mem_raddr  = wp_reg;
                state_next = S_W_POST;
            end
            else
            begin
                if (md_st == ST_OK && op_reg == OP_RESIZE)
                begin
                    res_next = '{status: ST_OK, para_out: rp_abs, size_out: req_reg};
                end
                else
                begin
                    res_next = '{status: md_st, para_out: '0, size_out: '0};
                end
                state_next = S_FIN;
            end
        end

        // step to the next header of a full chain walk
        if (walk_adv)
        begin
            if (d.last)
            begin
                res_next   = '{status: ST_OK, para_out: '0,
                               size_out: (op_reg == OP_LARGEST) ? best_upd[REQ_W-1:0]
                                                                 : REQ_W'(0)};
                state_next = S_FIN;
            end
            else if (wnxt >= LIM)
            begin
                res_next   = '{status: ST_CORRUPT, para_out: '0, size_out: '0};
                state_next = S_FIN;
            end
            else
            begin
                wp_next    = wnxt[ADDR_W-1:0];
                mem_raddr  = wnxt[ADDR_W-1:0];
                state_next = S_W_DATA;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            op_reg        <= '0;
            req_reg       <= '0;
            own_reg       <= '0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            mp_reg        <= '0;
            q_reg         <= '0;
            n_reg         <= '0;
            cand_reg      <= '0;
            clr_reg       <= '0;
            hp_reg        <= '0;
            hq_reg        <= '0;
            found_reg     <= 1'b0;
            clast_reg     <= 1'b0;
            csz_reg       <= '0;
            best_reg      <= '0;
            steps_reg     <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            req_reg       <= req_next;
            own_reg       <= own_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            mp_reg        <= mp_next;
            q_reg         <= q_next;
            n_reg         <= n_next;
            cand_reg      <= cand_next;
            clr_reg       <= clr_next;
            hp_reg        <= hp_next;
            hq_reg        <= hq_next;
            found_reg     <= found_next;
            clast_reg     <= clast_next;
            csz_reg       <= csz_next;
            best_reg      <= best_next;
            steps_reg     <= steps_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

`default_nettype wire

### hdl/paragraph_block_allocator_unit.sv
// Each walk reads the chain headers one at a time, with set-up and write-back around the walk;
// free and shrinking resize add a merge pass over the chain from its first header.
// Throughput: one operation at a time, bound by the single read port of the header RAM.
// Reset: a clearing sweep writes all ARENA_PARAS headers; in_stall is high
// until it ends. Configuration writes are taken throughout.
`default_nettype none

module paragraph_block_allocator_unit
    import pba_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire pba_req_t           in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output pba_rsp_t                out_data,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_index,
    input  wire logic [PARA_W-1:0]  cfg_data
);

    logic [1:0]         strategy_reg;
    logic [PARA_W-1:0]  base_reg;
    mem_wr_t            mem_wr;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [HDR_W-1:0]   mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strategy_reg <= FIT_FIRST;
            base_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_STRATEGY: strategy_reg <= cfg_data[1:0];
                CFG_BASE:     base_reg     <= cfg_data;
                default:      base_reg     <= base_reg;
            endcase
        end
    end

    pba_ram #(
        .WIDTH (HDR_W),
        .DEPTH (ARENA_PARAS)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (mem_wr.we),
        .waddr (mem_wr.addr),
        .wdata (mem_wr.data),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .strategy  (strategy_reg),
        .base      (base_reg),
        .mem_wr    (mem_wr),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

### hdl/pba_checker.sv
// Port-level checks on the allocator, bound to the top level
`default_nettype none

module pba_checker
    import pba_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire pba_req_t           in_data,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire pba_rsp_t           out_data
);

    // one operation in flight: the input side closes after each beat
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an operation is in progress");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("stalled input beat changed");

    a_para_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.para_out == '0)
        else $error("block paragraph reported with a failing status");

    a_no_size_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_CORRUPT || out_data.status == ST_INVALID)
        |-> out_data.size_out == '0)
        else $error("size reported with a corrupt or invalid status");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

endmodule

bind paragraph_block_allocator_unit pba_checker u_pba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
